/* sv/sai_pkg.sv */
`default_nettype none

package sai_pkg;

    // Tick scale of the free-running counter
    localparam int unsigned MS_PER_TICK = 1;

    // Port geometry
    localparam int unsigned IN_FIELDS_W  = 147;
    localparam int unsigned IN_TDATA_W   = 152;
    localparam int unsigned OUT_TDATA_W  = 8;
    localparam int unsigned CFG_INDEX_W  = 2;
    localparam int unsigned CFG_DATA_W   = 16;

    // Half scale in Q2.14, held one bit wider than a stick value
    localparam logic signed [16:0] HALF_Q14 = 17'sd8192;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_ARMING_MODE    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_ARM_HOLD       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DISARM_HOLD    = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDLE_TIMEOUT   = 2'd3;

    // Arming modes
    localparam logic [3:0] MODE_ALWAYS_DISARMED = 4'd0;
    localparam logic [3:0] MODE_ALWAYS_ARMED    = 4'd1;
    localparam logic [3:0] MODE_ROLL_LEFT       = 4'd2;
    localparam logic [3:0] MODE_ROLL_RIGHT      = 4'd3;
    localparam logic [3:0] MODE_PITCH_FWD       = 4'd4;
    localparam logic [3:0] MODE_PITCH_AFT       = 4'd5;
    localparam logic [3:0] MODE_YAW_LEFT        = 4'd6;
    localparam logic [3:0] MODE_YAW_RIGHT       = 4'd7;
    localparam logic [3:0] MODE_ACC_A           = 4'd8;
    localparam logic [3:0] MODE_ACC_B           = 4'd9;
    localparam logic [3:0] MODE_ACC_C           = 4'd10;

    // Published status codes
    localparam logic [1:0] ST_DISARMED = 2'd0;
    localparam logic [1:0] ST_ARMING   = 2'd1;
    localparam logic [1:0] ST_ARMED    = 2'd2;

    // Reset values of the registers
    localparam logic [15:0] ARM_HOLD_RESET     = 16'd1000;
    localparam logic [15:0] DISARM_HOLD_RESET  = 16'd1000;
    localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd0;

    typedef enum logic [2:0] {
        PH_DISARMED          = 3'd0,
        PH_ARMING            = 3'd1,
        PH_ARMED             = 3'd2,
        PH_DISARMING_MANUAL  = 3'd3,
        PH_DISARMING_TIMEOUT = 3'd4
    } phase_t;

    // One control tick, last field in the lowest bits
    typedef struct packed {
        logic               force_disarm;
        logic               safe_to_arm;
        logic signed [15:0] accessory_c;
        logic signed [15:0] accessory_b;
        logic signed [15:0] accessory_a;
        logic signed [15:0] yaw;
        logic signed [15:0] pitch;
        logic signed [15:0] roll;
        logic signed [15:0] throttle;
        logic [31:0]        now_tick;
        logic               reinit;
    } item_t;

    typedef struct packed {
        logic [3:0]  arming_mode;
        logic [15:0] arm_hold_ms;
        logic [15:0] disarm_hold_ms;
        logic [15:0] armed_idle_timeout_ms;
    } cfg_t;

    typedef struct packed {
        phase_t      phase;
        logic [31:0] window_start;
        logic [1:0]  published;
    } arm_state_t;

endpackage

`default_nettype wire

/* sv/sai_step.sv */
`default_nettype none

module sai_step (
    input  var sai_pkg::item_t      item,
    input  var sai_pkg::cfg_t       cfg,
    input  var sai_pkg::arm_state_t cur,
    output sai_pkg::arm_state_t     nxt,
    output logic [1:0]              armed_status,
    output logic                    status_changed
);
    import sai_pkg::*;

    phase_t             phase0;
    logic [1:0]         pub0;
    logic               sw;
    logic signed [16:0] acc;
    logic signed [16:0] level;
    logic               low;
    logic               want_arm;
    logic               want_disarm;
    logic [31:0]        elapsed;

    // Reinit clears phase and status ahead of the tick
    assign phase0 = item.reinit ? PH_DISARMED : cur.phase;
    assign pub0   = item.reinit ? ST_DISARMED : cur.published;

    // Pick the accessory switch in accessory modes
    always_comb
    begin
        sw  = 1'b1;
        acc = '0;
        case (cfg.arming_mode)
            MODE_ACC_A: acc = {item.accessory_a[15], item.accessory_a};
            MODE_ACC_B: acc = {item.accessory_b[15], item.accessory_b};
            MODE_ACC_C: acc = {item.accessory_c[15], item.accessory_c};
            default:    sw  = 1'b0;
        endcase
    end

    assign low = item.throttle[15] || (sw && (acc <= -HALF_Q14));

    // Gesture level per mode; unused modes read zero
    always_comb
    begin
        case (cfg.arming_mode)
            MODE_ROLL_LEFT:  level = {item.roll[15], item.roll};
            MODE_ROLL_RIGHT: level = -{item.roll[15], item.roll};
            MODE_PITCH_FWD:  level = {item.pitch[15], item.pitch};
            MODE_PITCH_AFT:  level = -{item.pitch[15], item.pitch};
            MODE_YAW_LEFT:   level = {item.yaw[15], item.yaw};
            MODE_YAW_RIGHT:  level = -{item.yaw[15], item.yaw};
            MODE_ACC_A, MODE_ACC_B, MODE_ACC_C: level = -acc;
            default:         level = '0;
        endcase
    end

    assign want_arm    = level <= -HALF_Q14;
    assign want_disarm = !want_arm && (level >= HALF_Q14);

    // Time since the window opened, wrapping with the tick counter
    assign elapsed = 32'((item.now_tick - cur.window_start) * MS_PER_TICK);

    // Advance the arming machine
    always_comb
    begin
        nxt.phase        = phase0;
        nxt.window_start = cur.window_start;
        nxt.published    = pub0;
        if (item.force_disarm || cfg.arming_mode == MODE_ALWAYS_DISARMED)
        begin
            nxt.published = ST_DISARMED;
        end
        else if (!low)
        begin
            if (phase0 == PH_DISARMING_MANUAL || phase0 == PH_DISARMING_TIMEOUT)
                nxt.phase = PH_ARMED;
            else if (phase0 == PH_ARMING)
                nxt.phase = PH_DISARMED;
        end
        else if (cfg.arming_mode == MODE_ALWAYS_ARMED)
        begin
            nxt.published = ST_ARMED;
        end
        else
        begin
            case (phase0)
                PH_DISARMED:
                begin
                    nxt.published = ST_DISARMED;
                    if (want_arm && item.safe_to_arm)
                    begin
                        nxt.window_start = item.now_tick;
                        nxt.phase        = PH_ARMING;
                    end
                end
                PH_ARMING:
                begin
                    nxt.published = ST_ARMING;
                    if (want_arm && elapsed > {16'd0, cfg.arm_hold_ms})
                        nxt.phase = PH_ARMED;
                    else if (!want_arm)
                        nxt.phase = PH_DISARMED;
                end
                PH_ARMED:
                begin
                    nxt.window_start = item.now_tick;
                    nxt.phase        = PH_DISARMING_TIMEOUT;
                    nxt.published    = ST_ARMED;
                end
                PH_DISARMING_TIMEOUT:
                begin
                    if (cfg.armed_idle_timeout_ms != '0
                        && elapsed > {16'd0, cfg.armed_idle_timeout_ms})
                        nxt.phase = PH_DISARMED;
                    if (want_disarm)
                    begin
                        nxt.window_start = item.now_tick;
                        nxt.phase        = PH_DISARMING_MANUAL;
                    end
                end
                PH_DISARMING_MANUAL:
                begin
                    if (want_disarm && elapsed > {16'd0, cfg.disarm_hold_ms})
                        nxt.phase = PH_DISARMED;
                    else if (!want_disarm)
                        nxt.phase = PH_ARMED;
                end
                default:
                begin
                    nxt.phase = PH_DISARMED;
                end
            endcase
        end
    end

    // Result of the tick
    assign armed_status   = nxt.published;
    assign status_changed = nxt.published != cur.published;

endmodule

`default_nettype wire

/* sv/stick_arming_interlock.sv */
// Each beat passes the input register, then the result register, to m_axis.
// Throughput: one tick per cycle; the input register and the result register
// both advance whenever the result register is empty or being taken.
// The whole arming decision is one pass of logic between those registers.
// Reset (rst_n low, asynchronous): phase disarmed, window start 0, status
// disarmed, both pipeline slots empty, registers at their reset values.
`default_nettype none

module stick_arming_interlock (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    // reinit, now_tick, throttle, roll, pitch, yaw, accessory_a,
    // accessory_b, accessory_c, safe_to_arm, force_disarm (low bit up)
    input  wire logic [sai_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  wire logic                             s_axis_tvalid,
    output logic                                  s_axis_tready,
    // armed_status, status_changed (low bit up)
    output logic [sai_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic                             cfg_valid,
    output logic                                  cfg_ready,
    input  wire logic [sai_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [sai_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sai_pkg::*;

    cfg_t       cfg_reg;
    arm_state_t state_reg;
    arm_state_t state_next;
    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    logic [1:0] out_status_reg;
    logic       out_changed_reg;
    logic [1:0] status_next;
    logic       changed_next;
    logic       advance;

    assign cfg_ready = 1'b1;

    // Move the input slot into the result slot when the result slot frees up
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    // Hold the configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.arming_mode           <= MODE_ALWAYS_DISARMED;
            cfg_reg.arm_hold_ms           <= ARM_HOLD_RESET;
            cfg_reg.disarm_hold_ms        <= DISARM_HOLD_RESET;
            cfg_reg.armed_idle_timeout_ms <= IDLE_TIMEOUT_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ARMING_MODE:  cfg_reg.arming_mode           <= cfg_data[3:0];
                CFG_ARM_HOLD:     cfg_reg.arm_hold_ms           <= cfg_data;
                CFG_DISARM_HOLD:  cfg_reg.disarm_hold_ms        <= cfg_data;
                CFG_IDLE_TIMEOUT: cfg_reg.armed_idle_timeout_ms <= cfg_data;
                default:          ;
            endcase
        end
    end

    // Input slot valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    // Capture the input beat
    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
            in_item_reg <= item_t'(s_axis_tdata[IN_FIELDS_W-1:0]);
    end

    sai_step u_step (
        .item           (in_item_reg),
        .cfg            (cfg_reg),
        .cur            (state_reg),
        .nxt            (state_next),
        .armed_status   (status_next),
        .status_changed (changed_next)
    );

    // Commit the arming state once per tick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.phase        <= PH_DISARMED;
            state_reg.window_start <= '0;
            state_reg.published    <= ST_DISARMED;
        end
        else if (advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result slot valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    // Capture the result beat
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_status_reg  <= status_next;
            out_changed_reg <= changed_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {(OUT_TDATA_W - 3)'(0), out_changed_reg, out_status_reg};

endmodule

`default_nettype wire

/* sv/sai_checker.sv */
`default_nettype none

module sai_checker (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic [sai_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  wire logic                             m_axis_tvalid,
    input  wire logic                             m_axis_tready,
    input  wire logic                             cfg_valid,
    input  wire logic                             cfg_ready,
    input  wire logic [sai_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  wire logic [sai_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import sai_pkg::*;

    logic [1:0] last_status_reg;
    logic [3:0] mode_reg;

    // Track the last delivered status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            last_status_reg <= ST_DISARMED;
        else if (m_axis_tvalid && m_axis_tready)
            last_status_reg <= m_axis_tdata[1:0];
    end

    // Track the arming mode written on the config channel
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            mode_reg <= MODE_ALWAYS_DISARMED;
        else if (cfg_valid && cfg_ready && cfg_index == CFG_ARMING_MODE)
            mode_reg <= cfg_data[3:0];
    end

    // Status is never the unused code
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[1:0] == ST_DISARMED
            || m_axis_tdata[1:0] == ST_ARMING || m_axis_tdata[1:0] == ST_ARMED))
        else $error("armed_status carries an unused code");

    // Change flag agrees with the previously delivered status
    a_change_flag: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2] == (m_axis_tdata[1:0] != last_status_reg)))
        else $error("status_changed disagrees with previous status");

    // Always-disarmed mode publishes disarmed only
    a_mode_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && mode_reg == MODE_ALWAYS_DISARMED)
            |-> m_axis_tdata[1:0] == ST_DISARMED)
        else $error("status not disarmed in always-disarmed mode");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result beat changed");

endmodule

bind stick_arming_interlock sai_checker u_sai_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
);

`default_nettype wire
